[hw/rtl/ppsc_pkg.sv]
package ppsc_pkg;

   localparam int PalEntries  = 256;
   localparam int EntryWidth  = $clog2(PalEntries);
   localparam int CountWidth  = 11;
   localparam int QueueDepth  = 4;

   localparam logic [CountWidth-1:0] HeaderBytes  = CountWidth'(8);
   localparam logic [CountWidth-1:0] RedStart     = HeaderBytes;
   localparam logic [CountWidth-1:0] GreenStart   = CountWidth'(8 + PalEntries);
   localparam logic [CountWidth-1:0] BlueStart    = CountWidth'(8 + 2 * PalEntries);
   localparam logic [CountWidth-1:0] BlueEnd      = CountWidth'(8 + 3 * PalEntries);
   localparam logic [CountWidth-1:0] MinFileBytes = CountWidth'(8 + 6 * PalEntries);
   localparam logic [CountWidth-1:0] CountMax     = {CountWidth{1'b1}};

   localparam logic [EntryWidth-1:0] TerrainFirst = EntryWidth'(160);
   localparam logic [EntryWidth-1:0] LastEntry    = EntryWidth'(PalEntries - 1);
   localparam logic [31:0]           ShadowArgb   = 32'h7000_0000;
   localparam logic [7:0]            Opaque       = 8'hFF;

   typedef enum logic [1:0] {
      CSR_STANDARD_GAIN = 2'd0,
      CSR_TERRAIN_GAIN  = 2'd1,
      CSR_LEVEL_OFFSET  = 2'd2,
      CSR_SHADOW_ENTRY  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      HDR_OK          = 2'd0,
      HDR_BAD_TAG     = 2'd1,
      HDR_BAD_VERSION = 2'd2
   } hdr_status_type;

   typedef enum logic [2:0] {
      KIND_COLOR       = 3'd0,
      KIND_FILE_OK     = 3'd1,
      KIND_BAD_TAG     = 3'd2,
      KIND_BAD_VERSION = 3'd3,
      KIND_TOO_SHORT   = 3'd4
   } result_kind_type;

   // one queue entry: an optional color followed by an optional status
   typedef struct packed {
      logic                  has_color;
      logic                  has_status;
      result_kind_type       status_kind;
      logic [EntryWidth-1:0] entry;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
   } job_type;

   typedef struct packed {
      logic [7:0]       standard_gain;
      logic [7:0]       terrain_gain;
      logic signed [8:0] level_offset;
      logic signed [8:0] shadow_entry;
   } cfg_type;

   function automatic logic [7:0] header_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h50;
         3'd1: b = 8'h41;
         3'd2: b = 8'h4C;
         3'd3: b = 8'h53;
         3'd4: b = 8'h02;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[hw/rtl/ppsc_req_if.sv]
interface ppsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

[hw/rtl/ppsc_rsp_if.sv]
interface ppsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [7:0]  entry_number;
   logic [31:0] argb_color;
   logic        final_result;

   modport source (output valid, output result_kind, output entry_number,
                   output argb_color, output final_result, input ready);
   modport sink   (input valid, input result_kind, input entry_number,
                   input argb_color, input final_result, output ready);
endinterface

[hw/rtl/ppsc_ram.sv]
module ppsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ppsc_front.sv]
module ppsc_front
   import ppsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ppsc_req_if.sink      req_chan,
   input  logic          q_full,
   output logic          q_push,
   output job_type       q_job
);

   logic [CountWidth-1:0] count_ff, count_in, count_inc;
   hdr_status_type        hdr_ff, hdr_in, hdr_upd;
   logic                  s1_valid_ff, s1_valid_in;
   job_type               s1_job_ff, s1_job_in;

   logic                  accept;
   logic                  in_header, in_red, in_green, in_blue;
   logic                  emit_color, produce;
   logic [CountWidth-1:0] red_off, green_off, blue_off;
   logic [EntryWidth-1:0] red_addr, green_addr, blue_entry;
   logic [7:0]            red_rd, green_rd;
   result_kind_type       status_kind;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || !q_full;

   assign in_header = count_ff < HeaderBytes;
   assign in_red    = !in_header && (count_ff < GreenStart);
   assign in_green  = (count_ff >= GreenStart) && (count_ff < BlueStart);
   assign in_blue   = (count_ff >= BlueStart) && (count_ff < BlueEnd);

   assign red_off    = count_ff - RedStart;
   assign green_off  = count_ff - GreenStart;
   assign blue_off   = count_ff - BlueStart;
   assign red_addr   = red_off[EntryWidth-1:0];
   assign green_addr = green_off[EntryWidth-1:0];
   assign blue_entry = blue_off[EntryWidth-1:0];

   assign count_inc  = (count_ff < CountMax) ? count_ff + 1'b1 : count_ff;
   assign emit_color = in_blue && (hdr_ff == HDR_OK);
   assign produce    = emit_color || req_chan.end_of_file;

   // keep only the first header error
   always_comb begin
      hdr_upd = hdr_ff;
      if (in_header && hdr_ff == HDR_OK &&
          req_chan.data_byte != header_byte(count_ff[2:0])) begin
         hdr_upd = (count_ff < CountWidth'(4)) ? HDR_BAD_TAG : HDR_BAD_VERSION;
      end
   end

   always_comb begin
      if (count_inc < MinFileBytes) begin
         status_kind = KIND_TOO_SHORT;
      end else begin
         case (hdr_upd)
            HDR_OK:          status_kind = KIND_FILE_OK;
            HDR_BAD_TAG:     status_kind = KIND_BAD_TAG;
            HDR_BAD_VERSION: status_kind = KIND_BAD_VERSION;
            default:         status_kind = KIND_FILE_OK;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      hdr_in   = hdr_ff;
      if (accept) begin
         if (req_chan.end_of_file) begin
            count_in = '0;
            hdr_in   = HDR_OK;
         end else begin
            count_in = count_inc;
            hdr_in   = hdr_upd;
         end
      end
   end

   assign q_push = s1_valid_ff && !q_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept && produce) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s1_job_in             = s1_job_ff;
      if (accept && produce) begin
         s1_job_in.has_color   = emit_color;
         s1_job_in.has_status  = req_chan.end_of_file;
         s1_job_in.status_kind = status_kind;
         s1_job_in.entry       = blue_entry;
         s1_job_in.red         = '0;
         s1_job_in.green       = '0;
         s1_job_in.blue        = req_chan.data_byte;
      end
   end

   // plane data arrives the cycle after the blue beat, aligned with s1
   always_comb begin
      q_job       = s1_job_ff;
      q_job.red   = red_rd;
      q_job.green = green_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         hdr_ff      <= HDR_OK;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         hdr_ff      <= hdr_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_job_ff <= s1_job_in;
   end

   ppsc_ram #(.WIDTH(8), .DEPTH(PalEntries)) u_red_plane (
      .clock   (clock),
      .wr_en   (accept && in_red),
      .wr_addr (red_addr),
      .wr_data (req_chan.data_byte),
      .rd_en   (accept && emit_color),
      .rd_addr (blue_entry),
      .rd_data (red_rd)
   );

   ppsc_ram #(.WIDTH(8), .DEPTH(PalEntries)) u_green_plane (
      .clock   (clock),
      .wr_en   (accept && in_green),
      .wr_addr (green_addr),
      .wr_data (req_chan.data_byte),
      .rd_en   (accept && emit_color),
      .rd_addr (blue_entry),
      .rd_data (green_rd)
   );

endmodule

[hw/rtl/ppsc_queue.sv]
module ppsc_queue
   import ppsc_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PtrWidth = $clog2(DEPTH);
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

   job_type               entries_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full       = count_ff == CntWidth'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hw/rtl/ppsc_back.sv]
module ppsc_back
   import ppsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   ppsc_rsp_if.source rsp_chan
);

   logic            rsp_valid_ff, rsp_valid_in;
   result_kind_type kind_ff, kind_in;
   logic [7:0]      entry_ff, entry_in;
   logic [31:0]     argb_ff, argb_in;
   logic            final_ff, final_in;
   logic            color_done_ff, color_done_in;

   logic            out_free, send_color, send_status;
   logic [7:0]      gain;
   logic [31:0]     color;

   function automatic logic [7:0] scale_channel(input logic [7:0] c,
                                                 input logic [7:0] g,
                                                 input logic signed [8:0] off);
      logic [15:0]        prod;
      logic signed [17:0] sum;
      logic [7:0]         res;
      prod = c * g;
      sum  = signed'({2'b00, prod}) + signed'({{9{off[8]}}, off});
      if (sum[17]) begin
         res = 8'h00;
      end else if (sum > 18'sd255) begin
         res = 8'hFF;
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

   assign gain = (head_job.entry < TerrainFirst || head_job.entry == LastEntry)
                 ? cfg.standard_gain : cfg.terrain_gain;

   always_comb begin
      if (!cfg.shadow_entry[8] && cfg.shadow_entry[7:0] == head_job.entry) begin
         color = ShadowArgb;
      end else if (head_job.entry == '0) begin
         color = '0;
      end else begin
         color = {Opaque,
                  scale_channel(head_job.red,   gain, cfg.level_offset),
                  scale_channel(head_job.green, gain, cfg.level_offset),
                  scale_channel(head_job.blue,  gain, cfg.level_offset)};
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign send_color  = head_valid && out_free && head_job.has_color && !color_done_ff;
   assign send_status = head_valid && out_free && !send_color && head_job.has_status;
   // drop the head once its last beat is loaded
   assign pop = send_status || (send_color && !head_job.has_status);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      entry_in      = entry_ff;
      argb_in       = argb_ff;
      final_in      = final_ff;
      color_done_in = color_done_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (send_color) begin
         rsp_valid_in  = 1'b1;
         kind_in       = KIND_COLOR;
         entry_in      = head_job.entry;
         argb_in       = color;
         final_in      = 1'b0;
         color_done_in = head_job.has_status;
      end else if (send_status) begin
         rsp_valid_in  = 1'b1;
         kind_in       = head_job.status_kind;
         entry_in      = '0;
         argb_in       = '0;
         final_in      = 1'b1;
         color_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         color_done_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         color_done_ff <= color_done_in;
      end
      kind_ff  <= kind_in;
      entry_ff <= entry_in;
      argb_ff  <= argb_in;
      final_ff <= final_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = kind_ff;
   assign rsp_chan.entry_number = entry_ff;
   assign rsp_chan.argb_color   = argb_ff;
   assign rsp_chan.final_result = final_ff;

endmodule

[hw/rtl/planar_palette_stream_converter.sv]
// Palette file converter: one file byte is taken per cycle unless the queue is
// full, with no gaps between files and no start-up sweep after reset. The front
// end checks the PALS tag and version, writes red and green bytes into two
// 256 x 8 plane RAMs and, on each blue byte of a file with a good header, reads
// both planes at that entry in the same cycle. A small queue carries the work
// to the back end, which scales, offsets and clamps the three channels and
// loads one result per cycle, while the output is free, into the output
// register. A byte that both closes a color and ends the file gives two beats,
// color then status.
module planar_palette_stream_converter
   import ppsc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   ppsc_req_if.sink   req_chan,
   ppsc_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_pop, q_full, q_head_valid;
   job_type q_push_job, q_head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_STANDARD_GAIN: cfg_in.standard_gain = csr_write_data[7:0];
            CSR_TERRAIN_GAIN:  cfg_in.terrain_gain  = csr_write_data[7:0];
            CSR_LEVEL_OFFSET:  cfg_in.level_offset  = csr_write_data;
            CSR_SHADOW_ENTRY:  cfg_in.shadow_entry  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.standard_gain <= 8'd1;
         cfg_ff.terrain_gain  <= 8'd1;
         cfg_ff.level_offset  <= '0;
         cfg_ff.shadow_entry  <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (q_push_job)
   );

   ppsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   ppsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full || q_pop)
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("queue pop while empty");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.final_result |->
         rsp_chan.argb_color == '0 && rsp_chan.entry_number == '0 &&
         rsp_chan.result_kind != KIND_COLOR)
      else $error("status beat carries color data");

   a_color_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.final_result |-> rsp_chan.result_kind == KIND_COLOR)
      else $error("color beat has a status kind");

endmodule

[bench/ppsc_bench_pkg.sv]
package ppsc_bench_pkg;
   import ppsc_pkg::*;

   // tag "PALS" then version 2 as a little-endian 32-bit word, byte 0 lowest
   localparam logic [63:0] FileHeader = 64'h0000_0002_534C_4150;

   typedef logic [7:0] file_bytes_type[$];

   typedef enum {
      FLAW_NONE,
      FLAW_TAG,
      FLAW_VERSION,
      FLAW_BOTH
   } header_flaw_type;

   typedef struct {
      result_kind_type kind;
      logic [7:0]      entry;
      logic [31:0]     argb;
      logic            last;
   } palette_beat_type;

   class palette_converter_mirror;
      logic [7:0]            standard_gain;
      logic [7:0]            terrain_gain;
      logic signed [8:0]     level_offset;
      logic signed [8:0]     shadow_entry;
      logic [CountWidth-1:0] byte_count;
      hdr_status_type        header_state;
      logic [7:0]            red_plane[PalEntries];
      logic [7:0]            green_plane[PalEntries];
      palette_beat_type      awaited_beats[$];
      int unsigned           mismatch_count;

      function new();
         standard_gain  = 8'd1;
         terrain_gain   = 8'd1;
         level_offset   = '0;
         shadow_entry   = -9'sd1;
         byte_count     = '0;
         header_state   = HDR_OK;
         mismatch_count = 0;
         foreach (red_plane[i]) begin
            red_plane[i]   = '0;
            green_plane[i] = '0;
         end
      endfunction

      function void write_register(csr_index_type idx, logic [8:0] value);
         case (idx)
            CSR_STANDARD_GAIN: standard_gain = value[7:0];
            CSR_TERRAIN_GAIN:  terrain_gain  = value[7:0];
            CSR_LEVEL_OFFSET:  level_offset  = value;
            CSR_SHADOW_ENTRY:  shadow_entry  = value;
            default: ;
         endcase
      endfunction

      function logic [7:0] scaled(logic [7:0] chan, logic [7:0] gain);
         int level;
         level = int'(chan) * int'(gain) + int'(level_offset);
         if (level < 0) return 8'd0;
         if (level > 255) return 8'hFF;
         return 8'(level);
      endfunction

      function logic [31:0] entry_argb(int entry, logic [7:0] blue);
         logic [7:0] gain;
         // shadow wins even over the transparent entry zero
         if (shadow_entry >= 0 && int'(shadow_entry) == entry) return ShadowArgb;
         if (entry == 0) return 32'd0;
         if (entry < int'(TerrainFirst) || entry == int'(LastEntry)) gain = standard_gain;
         else gain = terrain_gain;
         return {Opaque, scaled(red_plane[entry], gain), scaled(green_plane[entry], gain),
                 scaled(blue, gain)};
      endfunction

      function void note_file_byte(logic [7:0] data, logic eof);
         int               pos;
         int               entry;
         palette_beat_type beat;
         pos = int'(byte_count);
         if (pos < int'(HeaderBytes)) begin
            // keep only the first header error
            if (header_state == HDR_OK && data != FileHeader[8*pos +: 8]) begin
               if (pos < 4) header_state = HDR_BAD_TAG;
               else header_state = HDR_BAD_VERSION;
            end
         end else if (pos < int'(GreenStart)) begin
            red_plane[pos - int'(RedStart)] = data;
         end else if (pos < int'(BlueStart)) begin
            green_plane[pos - int'(GreenStart)] = data;
         end else if (pos < int'(BlueEnd) && header_state == HDR_OK) begin
            entry      = pos - int'(BlueStart);
            beat.kind  = KIND_COLOR;
            beat.entry = 8'(entry);
            beat.argb  = entry_argb(entry, data);
            beat.last  = 1'b0;
            awaited_beats.push_back(beat);
         end
         if (byte_count != CountMax) byte_count++;
         if (eof) begin
            if (byte_count < MinFileBytes) beat.kind = KIND_TOO_SHORT;
            else if (header_state == HDR_BAD_TAG) beat.kind = KIND_BAD_TAG;
            else if (header_state == HDR_BAD_VERSION) beat.kind = KIND_BAD_VERSION;
            else beat.kind = KIND_FILE_OK;
            beat.entry = 8'd0;
            beat.argb  = 32'd0;
            beat.last  = 1'b1;
            awaited_beats.push_back(beat);
            byte_count   = '0;
            header_state = HDR_OK;
         end
      endfunction

      function void check_beat(logic [2:0] kind, logic [7:0] entry, logic [31:0] argb,
                               logic last);
         palette_beat_type want;
         if (awaited_beats.size() == 0) begin
            $display("%0t: unexpected beat kind %0d entry %0d argb %h final %b",
                     $time, kind, entry, argb, last);
            mismatch_count++;
            return;
         end
         want = awaited_beats.pop_front();
         if (kind !== want.kind || entry !== want.entry || argb !== want.argb ||
             last !== want.last) begin
            $display("%0t: expected kind %0d entry %0d argb %h final %b", $time,
                     want.kind, want.entry, want.argb, want.last);
            $display("%0t: actual   kind %0d entry %0d argb %h final %b", $time,
                     kind, entry, argb, last);
            mismatch_count++;
         end
      endfunction
   endclass

endpackage

[bench/planar_palette_stream_converter_tb.sv]
module planar_palette_stream_converter_tb;
   import ppsc_pkg::*;
   import ppsc_bench_pkg::*;

   localparam int StallLimit     = 2000;
   localparam int LongHoldCycles = 300;
   localparam int SettleCycles   = 10;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [8:0] csr_write_data;

   ppsc_req_if req_chan();
   ppsc_rsp_if rsp_chan();

   planar_palette_stream_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   palette_converter_mirror mirror;

   int sender_gap_pct     = 0;
   int receiver_stall_pct = 0;
   bit long_hold_armed    = 1'b0;
   int quiet_cycles       = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off once results are flowing
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && long_hold_armed && rsp_chan.valid) begin
            long_hold_armed = 1'b0;
            hold_left = LongHoldCycles;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            mirror.note_file_byte(req_chan.data_byte, req_chan.end_of_file);
         if (rsp_chan.valid && rsp_chan.ready)
            mirror.check_beat(rsp_chan.result_kind, rsp_chan.entry_number,
                              rsp_chan.argb_color, rsp_chan.final_result);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_byte(logic [7:0] data, logic eof);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= data;
      req_chan.end_of_file <= eof;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_file(file_bytes_type content);
      foreach (content[i]) send_byte(content[i], i == content.size() - 1);
   endtask

   // hold the sender until every beat is back and the pipe has drained
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (mirror.awaited_beats.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= 9'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mirror.write_register(idx, 9'(value));
   endtask

   task automatic random_settings();
      write_register(CSR_STANDARD_GAIN, $urandom_range(255));
      write_register(CSR_TERRAIN_GAIN, $urandom_range(255));
      write_register(CSR_LEVEL_OFFSET, int'($urandom_range(510)) - 255);
      write_register(CSR_SHADOW_ENTRY, int'($urandom_range(256)) - 1);
   endtask

   // ramp gives red = entry, green = 255 - entry and a scrambled blue plane
   function automatic file_bytes_type build_file(int length, header_flaw_type flaw,
                                                 bit ramp);
      file_bytes_type content;
      logic [7:0]     b;
      int             pos;
      int             slot;
      int             plane_pos;
      for (pos = 0; pos < length; pos++) begin
         plane_pos = pos - int'(HeaderBytes);
         if (pos < int'(HeaderBytes)) b = FileHeader[8*pos +: 8];
         else if (ramp && plane_pos < PalEntries) b = 8'(plane_pos);
         else if (ramp && plane_pos < 2 * PalEntries) b = 8'(255 - plane_pos);
         else if (ramp && plane_pos < 3 * PalEntries) b = 8'(plane_pos * 37);
         else b = 8'($urandom);
         content.push_back(b);
      end
      if (flaw == FLAW_TAG || flaw == FLAW_BOTH) begin
         slot = $urandom_range(3);
         if (slot < length) content[slot] ^= 8'($urandom_range(1, 255));
      end
      if (flaw == FLAW_VERSION || flaw == FLAW_BOTH) begin
         slot = $urandom_range(4, 7);
         if (slot < length) content[slot] ^= 8'($urandom_range(1, 255));
      end
      return content;
   endfunction

   task automatic random_files(int count);
      int              choice;
      int              length;
      header_flaw_type flaw;
      repeat (count) begin
         choice = $urandom_range(99);
         flaw = FLAW_NONE;
         if (choice >= 85) flaw = header_flaw_type'($urandom_range(1, 3));
         if (choice < 12)
            length = $urandom_range(int'(BlueStart) + 1, int'(BlueEnd));
         else if (choice < 25)
            length = $urandom_range(1, int'(MinFileBytes) - 1);
         else
            length = int'(MinFileBytes) + $urandom_range(24);
         send_file(build_file(length, flaw, 1'b0));
         if ($urandom_range(3) == 0) settle();
      end
   endtask

   initial begin
      mirror = new();
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_STANDARD_GAIN;
      csr_write_data       = '0;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = '0;
      req_chan.end_of_file = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, no idling
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      send_file(build_file(4, FLAW_NONE, 1'b1));
      send_file(build_file(8, FLAW_TAG, 1'b1));
      send_file(build_file(int'(MinFileBytes), FLAW_NONE, 1'b1));
      // last color and the short-file status come from one byte
      send_file(build_file(int'(BlueEnd), FLAW_NONE, 1'b1));
      // tag and version both broken: tag error is reported
      send_file(build_file(int'(MinFileBytes), FLAW_BOTH, 1'b1));
      random_files(3);
      settle();

      write_register(CSR_STANDARD_GAIN, 255);
      write_register(CSR_TERRAIN_GAIN, 0);
      write_register(CSR_LEVEL_OFFSET, -255);
      write_register(CSR_SHADOW_ENTRY, 0);
      sender_gap_pct = 51;
      send_file(build_file(int'(MinFileBytes), FLAW_NONE, 1'b1));
      send_file(build_file(int'(MinFileBytes) + 3, FLAW_VERSION, 1'b1));
      random_files(3);
      settle();

      write_register(CSR_STANDARD_GAIN, 0);
      write_register(CSR_TERRAIN_GAIN, 255);
      write_register(CSR_LEVEL_OFFSET, 255);
      write_register(CSR_SHADOW_ENTRY, 255);
      sender_gap_pct     = 0;
      receiver_stall_pct = 51;
      long_hold_armed    = 1'b1;
      send_file(build_file(int'(MinFileBytes), FLAW_NONE, 1'b1));
      send_file(build_file(int'(BlueStart) + 1, FLAW_NONE, 1'b1));
      // run the byte count into saturation
      send_file(build_file(2100, FLAW_NONE, 1'b0));
      random_files(3);
      settle();

      random_settings();
      sender_gap_pct     = 26;
      receiver_stall_pct = 26;
      random_files(4);
      settle();

      random_settings();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      random_files(4);
      settle();

      if (mirror.mismatch_count == 0 && mirror.awaited_beats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
